// ===== sv/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_RANGE    = 3'd4,
    ST_END      = 3'd5
  } status_t;

  // Code point limits
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] POINT_MAX = 21'h10FFFF;
  localparam logic [20:0] PAIR_BASE = 21'h010000;

  // Upper six bits of high and low surrogates
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  // One classified request between front and back.
  // pair: val holds point - 0x10000 and gives two units.
  // otherwise: val[15:0] holds the unit (zero for errors).
  typedef struct packed {
    logic        pair;
    logic [19:0] val;
    status_t     status;
    logic        last;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, keeps the decode state and pushes one classified
// request per byte that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            in_stall,
  output logic            push,
  output entry_t          push_entry
);

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        skip_r, skip_nxt;

  logic        accept;
  logic        err;
  status_t     err_code;
  logic        done;
  logic [20:0] cp;
  logic [20:0] cont_cp;
  logic [19:0] cp_off;
  logic        want_push;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && want_push;

  // Accumulator shifted by one continuation byte
  assign cont_cp = {acc_r[14:0], in_byte[5:0]};
  // Offset above the pair base; only used for points 0x10000..0x10FFFF
  assign cp_off  = cp[19:0] - PAIR_BASE[19:0];

  // Decode one byte
  always_comb begin
    acc_nxt    = acc_r;
    pend_nxt   = pend_r;
    skip_nxt   = skip_r;
    want_push  = 1'b0;
    push_entry = '0;
    err        = 1'b0;
    err_code   = ST_OK;
    done       = 1'b0;
    cp         = '0;

    if (skip_r) begin
      // dropping bytes until the end of the string
      if (in_last) begin
        want_push         = 1'b1;
        push_entry.status = ST_END;
        push_entry.last   = 1'b1;
        acc_nxt           = '0;
        pend_nxt          = '0;
        skip_nxt          = 1'b0;
      end
    end else begin
      if (pend_r == 2'd0) begin
        // lead byte
        if (in_byte inside {[8'h00:8'h7F]}) begin
          cp   = {13'd0, in_byte};
          done = 1'b1;
        end else if (in_byte inside {[8'hC0:8'hDF]}) begin
          acc_nxt  = {16'd0, in_byte[4:0]};
          pend_nxt = 2'd1;
        end else if (in_byte inside {[8'hE0:8'hEF]}) begin
          acc_nxt  = {17'd0, in_byte[3:0]};
          pend_nxt = 2'd2;
        end else if (in_byte inside {[8'hF0:8'hF7]}) begin
          acc_nxt  = {18'd0, in_byte[2:0]};
          pend_nxt = 2'd3;
        end else begin
          err      = 1'b1;
          err_code = ST_BAD_LEAD;
        end
      end else begin
        // continuation byte must be 10xxxxxx
        if (in_byte[7:6] != 2'b10) begin
          err      = 1'b1;
          err_code = ST_BAD_CONT;
        end else begin
          acc_nxt  = cont_cp;
          pend_nxt = pend_r - 2'd1;
          if (pend_r == 2'd1) begin
            cp   = cont_cp;
            done = 1'b1;
          end
        end
      end

      // string cut short
      if (!err && !done && (pend_nxt != 2'd0) && in_last) begin
        err      = 1'b1;
        err_code = ST_TRUNC;
      end

      // completed point
      if (done) begin
        acc_nxt = '0;
        if ((cp >= SURR_LO && cp <= SURR_HI) || cp > POINT_MAX) begin
          err      = 1'b1;
          err_code = ST_RANGE;
        end else begin
          want_push         = 1'b1;
          push_entry.status = ST_OK;
          push_entry.last   = in_last;
          if (cp[20:16] != 5'd0) begin
            push_entry.pair = 1'b1;
            push_entry.val  = cp_off;
          end else begin
            push_entry.val  = {4'd0, cp[15:0]};
          end
        end
      end

      if (err) begin
        want_push         = 1'b1;
        push_entry        = '0;
        push_entry.status = err_code;
        push_entry.last   = in_last;
        acc_nxt           = '0;
        pend_nxt          = '0;
        skip_nxt          = !in_last;
      end
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      skip_r <= 1'b0;
    end else if (accept) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        empty,
  output entry_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        slot_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  // Pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LAST_IDX) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == LAST_IDX) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== sv/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Drains classified requests and emits UTF-16 results from an output
// register, splitting surrogate pairs over two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire entry_t q_head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [15:0] out_unit,
  output logic [2:0]  out_status,
  output logic        out_run_last,
  output logic        out_string_end
);

  logic        valid_r;
  logic        second_r, second_nxt;
  logic [15:0] unit_r, unit_nxt;
  status_t     status_r, status_nxt;
  logic        rl_r, rl_nxt;
  logic        se_r, se_nxt;
  logic        load;
  logic        have;

  assign out_valid      = valid_r;
  assign out_unit       = unit_r;
  assign out_status     = status_r;
  assign out_run_last   = rl_r;
  assign out_string_end = se_r;

  // Output register free to take a new result
  assign load = !valid_r || !out_stall;
  assign have = !q_empty;

  // Pick the next result from the queue head
  always_comb begin
    pop        = 1'b0;
    second_nxt = second_r;
    unit_nxt   = unit_r;
    status_nxt = status_r;
    rl_nxt     = rl_r;
    se_nxt     = se_r;
    if (load && have) begin
      status_nxt = q_head.status;
      if (second_r) begin
        // low surrogate closes the pair
        unit_nxt   = {LO_SURR_TAG, q_head.val[9:0]};
        rl_nxt     = 1'b1;
        se_nxt     = q_head.last;
        second_nxt = 1'b0;
        pop        = 1'b1;
      end else if (q_head.pair) begin
        // high surrogate; entry stays for its second half
        unit_nxt   = {HI_SURR_TAG, q_head.val[19:10]};
        rl_nxt     = 1'b0;
        se_nxt     = 1'b0;
        second_nxt = 1'b1;
      end else begin
        unit_nxt   = q_head.val[15:0];
        rl_nxt     = 1'b1;
        se_nxt     = q_head.last;
        pop        = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      valid_r  <= have;
      second_r <= second_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unit_r   <= unit_nxt;
    status_r <= status_nxt;
    rl_r     <= rl_nxt;
    se_r     <= se_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 code units and error status out.
//
// Input channel (in_valid / in_stall): one UTF-8 byte per request, with
// in_string_last set on the final byte of a string. Output channel
// (out_valid / out_stall): one UTF-16 unit or one error/end status per
// request; a point above 0xFFFF gives two requests (high then low
// surrogate). out_run_last marks the last result of a byte, out_string_end
// the last result of a string.
// Throughput: one byte per cycle unless in_stall; a pair keeps its queue
// entry until both surrogates are out. The front decodes a byte in the
// cycle it is accepted and queues it; results pass the queue, then the
// output register. When the receiver stalls the output register holds and
// the queue fills; in_stall rises once the queue (QDEPTH entries) is full.
// Reset empties the queue and clears the decode state; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_string_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_unit,
  output logic [2:0]       out_status,
  output logic             out_run_last,
  output logic             out_string_end
);

  logic   q_push;
  entry_t q_in;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  entry_t q_head;

  // Front: accept and classify
  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_last    (in_string_last),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Queue between the two halves
  u8u16_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back: emit results
  u8u16_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_unit       (out_unit),
    .out_status     (out_status),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

`default_nettype wire
